@@ hw/rtl/pirl_pkg.sv @@
// ---------------------------------------------------------------------------
// pirl_pkg: shared types and constants for the positional insert/remove list
// Request/response payloads, request and status codes, cell control.
// ---------------------------------------------------------------------------
package pirl_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int POS_W   = 16;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 5;
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

    // request kinds
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_LOOK   = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // per-cell operation
    localparam logic [1:0] CELL_HOLD = 2'd0;
    localparam logic [1:0] CELL_INS  = 2'd1;
    localparam logic [1:0] CELL_REM  = 2'd2;

    typedef struct packed {
        logic [1:0]               req_type;
        logic signed [POS_W-1:0]  position;
        logic signed [DATA_W-1:0] write_data;
    } t_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_data;
        logic [1:0]               status;
        logic [COUNT_W-1:0]       count;
    } t_rsp;

    typedef struct packed {
        logic [1:0]        op;
        logic [CNT_W-1:0]  pos;
        logic [DATA_W-1:0] data;
    } t_cell_ctl;

endpackage

@@ hw/rtl/pirl_cell.sv @@
// ---------------------------------------------------------------------------
// pirl_cell: one slot of the list
// Holds one word; on insert takes its lower neighbor or the new word, on
// remove takes its upper neighbor. Drives its word out when addressed.
// ---------------------------------------------------------------------------
module pirl_cell (
    input  logic                          i_clk,
    input  logic [pirl_pkg::CNT_W-1:0]    i_index,
    input  pirl_pkg::t_cell_ctl           i_ctl,
    input  logic [pirl_pkg::DATA_W-1:0]   i_lower_data,
    input  logic [pirl_pkg::DATA_W-1:0]   i_upper_data,
    output logic [pirl_pkg::DATA_W-1:0]   o_data,
    output logic [pirl_pkg::DATA_W-1:0]   o_read
);

    logic [pirl_pkg::DATA_W-1:0] r_data;
    logic [pirl_pkg::DATA_W-1:0] n_data;
    logic                        hit;
    logic                        above;

    assign hit   = (i_index == i_ctl.pos);
    assign above = (i_index > i_ctl.pos);

    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            pirl_pkg::CELL_INS: begin
                if (above) begin
                    n_data = i_lower_data;
                end else if (hit) begin
                    n_data = i_ctl.data;
                end
            end
            pirl_pkg::CELL_REM: begin
                if (above || hit) begin
                    n_data = i_upper_data;
                end
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_read = hit ? r_data : '0;

endmodule

@@ hw/rtl/positional_insert_remove_list_top.sv @@
// ---------------------------------------------------------------------------
// positional_insert_remove_list_top: position-addressed list of words
// Row of cells, one per slot; all cells compare and shift in the same cycle.
// ---------------------------------------------------------------------------
// Result: strobed on o_done in the cycle after the accepting edge.
// Throughput: one request per cycle; busy stays low, the cells at and above
//   the position shift in the same cycle as the request is taken.
// Reset: synchronous, active low; clears the entry count and o_done.
//   Slot contents are not cleared; only slots below the count are read.
// The receiver cannot stall; each result is shown for exactly one cycle.
module positional_insert_remove_list_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  pirl_pkg::t_req   i_req,
    output logic             busy,
    output logic             o_done,
    output pirl_pkg::t_rsp   o_rsp
);

    localparam int N = pirl_pkg::DEPTH;

    logic [pirl_pkg::CNT_W-1:0]  r_count;
    logic [pirl_pkg::CNT_W-1:0]  n_count;
    logic                        r_done;
    pirl_pkg::t_rsp              r_rsp;
    pirl_pkg::t_rsp              n_rsp;
    pirl_pkg::t_cell_ctl         ctl;

    logic                        accept;
    logic                        pos_neg;
    logic [pirl_pkg::CMP_W-1:0]  pos_u;
    logic [pirl_pkg::CMP_W-1:0]  count_u;
    logic                        full;
    logic                        in_range;
    logic [pirl_pkg::CNT_W-1:0]  ins_pos;
    logic [pirl_pkg::DATA_W-1:0] read_word;
    logic [pirl_pkg::CNT_W+pirl_pkg::COUNT_W-1:0] count_ext;

    logic [pirl_pkg::DATA_W-1:0] cell_data [N];
    logic [pirl_pkg::DATA_W-1:0] cell_read [N];

    assign accept   = start && !busy;
    assign busy     = 1'b0;
    assign pos_neg  = i_req.position[pirl_pkg::POS_W-1];
    assign pos_u    = pirl_pkg::CMP_W'(i_req.position[pirl_pkg::POS_W-2:0]);
    assign count_u  = pirl_pkg::CMP_W'(r_count);
    assign full     = (r_count == pirl_pkg::CNT_W'(pirl_pkg::DEPTH));
    assign in_range = !pos_neg && (pos_u < count_u);

    always_comb begin
        if (pos_neg) begin
            ins_pos = '0;
        end else if (pos_u > count_u) begin
            ins_pos = r_count;
        end else begin
            ins_pos = pos_u[pirl_pkg::CNT_W-1:0];
        end
    end

    // read select: only the addressed cell drives nonzero
    always_comb begin
        read_word = '0;
        for (int k = 0; k < N; k++) begin
            read_word = read_word | cell_read[k];
        end
    end

    always_comb begin
        ctl.op        = pirl_pkg::CELL_HOLD;
        ctl.pos       = pos_u[pirl_pkg::CNT_W-1:0];
        ctl.data      = i_req.write_data;
        n_count       = r_count;
        n_rsp.read_data = '0;
        n_rsp.status    = pirl_pkg::ST_OK;
        case (i_req.req_type)
            pirl_pkg::REQ_INSERT: begin
                ctl.pos = ins_pos;
                if (full) begin
                    n_rsp.status = pirl_pkg::ST_FULL;
                end else begin
                    ctl.op  = pirl_pkg::CELL_INS;
                    n_count = r_count + 1'b1;
                end
            end
            pirl_pkg::REQ_REMOVE, pirl_pkg::REQ_LOOK: begin
                if (!in_range) begin
                    n_rsp.status = pirl_pkg::ST_INVALID;
                end else begin
                    n_rsp.read_data = read_word;
                    if (i_req.req_type == pirl_pkg::REQ_REMOVE) begin
                        ctl.op  = pirl_pkg::CELL_REM;
                        n_count = r_count - 1'b1;
                    end
                end
            end
            default: n_count = r_count;
        endcase
        if (!accept) begin
            ctl.op  = pirl_pkg::CELL_HOLD;
            n_count = r_count;
        end
        count_ext   = {{pirl_pkg::COUNT_W{1'b0}}, n_count};
        n_rsp.count = count_ext[pirl_pkg::COUNT_W-1:0];
    end

    for (genvar g = 0; g < N; g++) begin : g_cell
        logic [pirl_pkg::DATA_W-1:0] lower;
        logic [pirl_pkg::DATA_W-1:0] upper;
        if (g == 0) begin : g_first
            assign lower = i_req.write_data;
        end else begin : g_mid_lo
            assign lower = cell_data[g-1];
        end
        if (g == N - 1) begin : g_last
            assign upper = cell_data[g];
        end else begin : g_mid_hi
            assign upper = cell_data[g+1];
        end
        pirl_cell u_cell (
            .i_clk        (i_clk),
            .i_index      (pirl_pkg::CNT_W'(g)),
            .i_ctl        (ctl),
            .i_lower_data (lower),
            .i_upper_data (upper),
            .o_data       (cell_data[g]),
            .o_read       (cell_read[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

@@ hw/rtl/pirl_checker.sv @@
// ---------------------------------------------------------------------------
// pirl_props: port-level checks for the positional insert/remove list
// One result per accepted transaction, and consistency of status fields.
// ---------------------------------------------------------------------------
module pirl_props (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input pirl_pkg::t_req i_req,
    input logic           busy,
    input logic           o_done,
    input pirl_pkg::t_rsp o_rsp
);

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_done)
        else $error("no result after accepted transaction");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy))
        else $error("result without transaction");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_rsp.status == pirl_pkg::ST_INVALID || o_rsp.status == pirl_pkg::ST_FULL))
        |-> (o_rsp.read_data == '0))
        else $error("nonzero data on failed transaction");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_req.req_type == pirl_pkg::REQ_INSERT)
         && o_rsp.status == pirl_pkg::ST_OK) |-> (o_rsp.count != '0))
        else $error("empty list after successful insert");

endmodule

bind positional_insert_remove_list_top pirl_props u_pirl_props (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .i_req   (i_req),
    .busy    (busy),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);
